### sv/alct_pkg.sv
// shared types and constants for the age counter lru tracker
// no dependencies; used by alct_cell and age_counter_lru_tracker

package alct_pkg;

    localparam int CAPACITY = 20;
    localparam int KEY_BITS = 16;
    localparam int ITEM_KEY_BITS = 16;
    localparam int AGE_BITS = 5;
    localparam logic [AGE_BITS-1:0] AGE_LAST = AGE_BITS'(CAPACITY - 1);

    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [AGE_BITS-1:0] t_age;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

    // control broadcast to every cell
    typedef struct packed {
        logic lookup;
        logic update;
        logic hit_any;
        t_key key;
        t_age hit_age;
    } t_cell_ctl;

    // priority chain passed from lower to higher numbered cells
    typedef struct packed {
        logic match_seen;
        logic evict_seen;
        logic free_seen;
    } t_chain;

    // per-cell contribution to the shared result
    typedef struct packed {
        logic hit;
        logic evict;
        t_age hit_age;
        t_key evict_key;
    } t_cell_out;

    // item key field to stored key width
    function automatic t_key to_key(input logic [ITEM_KEY_BITS-1:0] k);
        t_key r;
        for (int i = 0; i < KEY_BITS; i++) begin
            r[i] = (i < ITEM_KEY_BITS) ? k[i % ITEM_KEY_BITS] : 1'b0;
        end
        return r;
    endfunction

    // stored key to result field width
    function automatic logic [ITEM_KEY_BITS-1:0] from_key(input t_key k);
        logic [ITEM_KEY_BITS-1:0] r;
        for (int i = 0; i < ITEM_KEY_BITS; i++) begin
            r[i] = (i < KEY_BITS) ? k[i % KEY_BITS] : 1'b0;
        end
        return r;
    endfunction

endpackage

### sv/alct_cell.sv
// one tracker entry: valid bit, key and recency age
// depends on alct_pkg; instantiated in a row by age_counter_lru_tracker

module alct_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  alct_pkg::t_cell_ctl i_ctl,
    input  alct_pkg::t_chain    i_chain,
    output alct_pkg::t_chain    o_chain,
    output alct_pkg::t_cell_out o_out
);

    logic          r_valid;
    alct_pkg::t_key r_key;
    alct_pkg::t_age r_age;
    logic          r_hit;
    logic          r_evict_all;
    logic          r_evict_rep;

    logic key_eq;
    logic at_last;
    logic free_now;

    // compare and age-limit checks
    assign key_eq   = r_valid && (r_key == i_ctl.key);
    assign at_last  = r_valid && (r_age >= alct_pkg::AGE_LAST);
    assign free_now = !r_valid || r_evict_all;

    // priority chain to the next cell
    always_comb begin
        o_chain.match_seen = i_chain.match_seen | key_eq;
        o_chain.evict_seen = i_chain.evict_seen | at_last;
        o_chain.free_seen  = i_chain.free_seen | free_now;
    end

    // contribution to the shared result
    always_comb begin
        o_out.hit       = r_hit;
        o_out.evict     = r_evict_rep;
        o_out.hit_age   = r_hit ? r_age : '0;
        o_out.evict_key = r_evict_rep ? r_key : '0;
    end

    // lookup flags, registered in the lookup step and used by the later update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit       <= 1'b0;
            r_evict_all <= 1'b0;
            r_evict_rep <= 1'b0;
        end else if (i_ctl.lookup) begin
            r_hit       <= key_eq && !i_chain.match_seen;
            r_evict_all <= at_last;
            r_evict_rep <= at_last && !i_chain.evict_seen;
        end
    end

    // entry update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.update) begin
            if (i_ctl.hit_any) begin
                if (r_hit) begin
                    r_age <= '0;
                end else if (r_valid && (r_age < i_ctl.hit_age)) begin
                    r_age <= r_age + 1'b1;
                end
            end else if (free_now && !i_chain.free_seen) begin
                r_valid <= 1'b1;
                r_key   <= i_ctl.key;
                r_age   <= '0;
            end else if (r_evict_all) begin
                // aged out but not reused for the new key
                r_valid <= 1'b0;
            end else if (r_valid) begin
                r_age <= r_age + 1'b1;
            end
        end
    end

endmodule

### sv/age_counter_lru_tracker.sv
// Tracks up to CAPACITY (20) resident keys, each with a recency age held in a
// row of entry cells. A word goes from acceptance to its result in the output
// register in these steps: it is captured, then every cell compares its key
// and age checks in parallel and the lowest-numbered match or eviction is
// picked along the cell chain, then every cell updates its age, valid bit and
// key at once while the result is loaded. The input side takes no new word
// until the previous result is loaded; a result held by i_out_stall keeps
// the update step waiting. Ineligible words give an all-zero result and leave
// the entries untouched. There is no clearing pass after reset.
// depends on alct_pkg and alct_cell

module age_counter_lru_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_item_key,
    input  logic        i_eligible,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_hit,
    output logic        o_load_request,
    output logic        o_evict_valid,
    output logic [15:0] o_evict_key
);

    alct_pkg::t_state r_state;
    alct_pkg::t_state n_state;

    alct_pkg::t_key r_key;
    logic           r_elig;

    logic        r_out_valid;
    logic        r_hit;
    logic        r_load;
    logic        r_ev;
    logic [15:0] r_ev_key;

    logic in_take;
    logic out_free;
    logic res_load;
    logic ctl_lookup;
    logic ctl_update;

    alct_pkg::t_cell_ctl cell_ctl;
    alct_pkg::t_chain    chain [alct_pkg::CAPACITY+1];
    alct_pkg::t_cell_out cell_out [alct_pkg::CAPACITY];

    logic           hit_any;
    logic           ev_any;
    alct_pkg::t_age hit_age;
    alct_pkg::t_key ev_key;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= alct_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            alct_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = alct_pkg::ST_LOOKUP;
                end
            end
            alct_pkg::ST_LOOKUP: begin
                n_state = alct_pkg::ST_UPDATE;
            end
            alct_pkg::ST_UPDATE: begin
                if (out_free) begin
                    n_state = alct_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = alct_pkg::ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb begin
        o_in_stall = 1'b1;
        ctl_lookup = 1'b0;
        ctl_update = 1'b0;
        res_load   = 1'b0;
        unique case (r_state)
            alct_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            alct_pkg::ST_LOOKUP: begin
                ctl_lookup = 1'b1;
            end
            alct_pkg::ST_UPDATE: begin
                ctl_update = out_free && r_elig;
                res_load   = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // capture the incoming word
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_key  <= alct_pkg::to_key(i_item_key);
            r_elig <= i_eligible;
        end
    end

    // gather cell contributions
    always_comb begin
        hit_any = 1'b0;
        ev_any  = 1'b0;
        hit_age = '0;
        ev_key  = '0;
        for (int i = 0; i < alct_pkg::CAPACITY; i++) begin
            hit_any = hit_any | cell_out[i].hit;
            ev_any  = ev_any | cell_out[i].evict;
            hit_age = hit_age | cell_out[i].hit_age;
            ev_key  = ev_key | cell_out[i].evict_key;
        end
    end

    // control broadcast to the cells
    always_comb begin
        cell_ctl.lookup  = ctl_lookup;
        cell_ctl.update  = ctl_update;
        cell_ctl.hit_any = hit_any;
        cell_ctl.key     = r_key;
        cell_ctl.hit_age = hit_age;
    end

    // row of entry cells, chain starts empty at cell 0
    assign chain[0] = '0;

    for (genvar g = 0; g < alct_pkg::CAPACITY; g++) begin : g_cell
        alct_cell u_entry (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl),
            .i_chain (chain[g]),
            .o_chain (chain[g+1]),
            .o_out   (cell_out[g])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_hit    <= r_elig && hit_any;
            r_load   <= r_elig && !hit_any && chain[alct_pkg::CAPACITY].free_seen;
            r_ev     <= r_elig && !hit_any && ev_any;
            r_ev_key <= (r_elig && !hit_any) ? alct_pkg::from_key(ev_key) : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_load_request = r_load;
    assign o_evict_valid  = r_ev;
    assign o_evict_key    = r_ev_key;

endmodule
